[hw/rtl/frenet_to_cartesian_assert.svh]
// ----------------------------------------------------------------------------
// frenet_to_cartesian_assert.svh
// Assertion macros used by the checker file of the block.
// ----------------------------------------------------------------------------
`ifndef FRENET_TO_CARTESIAN_ASSERT_SVH
`define FRENET_TO_CARTESIAN_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define F2C_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("f2c assertion failed");

// Implication that holds in the cycle after the antecedent.
`define F2C_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("f2c assertion failed");

`endif

[hw/rtl/f2c_pkg.sv]
// ----------------------------------------------------------------------------
// f2c_pkg
// Shared constants, operation codes and control types of the converter.
// ----------------------------------------------------------------------------
`default_nettype none

package f2c_pkg;

	localparam int MAX_WP_DEFAULT = 256;
	localparam int STORE_DEPTH    = 256;
	localparam int UNIT_BITS      = 30;
	localparam int COUNT_W        = 9;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd2;
	localparam int PADDR_W        = 3;

	localparam logic REG_WAYPOINT_COUNT = 1'b0;

	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_CONVERT = 1'b1;

	localparam int ITER_W = 6;
	localparam logic [ITER_W-1:0] SQRT_STEPS = 6'd32;
	localparam logic [ITER_W-1:0] DIV_STEPS  = 6'd62;

	localparam logic [2:0] MUL_AXAX   = 3'd0;
	localparam logic [2:0] MUL_AYAY   = 3'd1;
	localparam logic [2:0] MUL_SEG_C  = 3'd2;
	localparam logic [2:0] MUL_D_SN   = 3'd3;
	localparam logic [2:0] MUL_SEG_SN = 3'd4;
	localparam logic [2:0] MUL_D_C    = 3'd5;

	localparam logic [2:0] ACC_HOLD    = 3'd0;
	localparam logic [2:0] ACC_CLR     = 3'd1;
	localparam logic [2:0] ACC_LOAD_X0 = 3'd2;
	localparam logic [2:0] ACC_LOAD_Y0 = 3'd3;
	localparam logic [2:0] ACC_ADD     = 3'd4;
	localparam logic [2:0] ACC_SUB     = 3'd5;

	typedef struct packed {
		logic       search_start;
		logic       search_step;
		logic       rd_prev;
		logic       rd_next;
		logic       cap_next;
		logic       abs_en;
		logic [2:0] mul_sel;
		logic [2:0] acc_op;
		logic       sqrt_start;
		logic       sqrt_step;
		logic       div_start;
		logic       div_step;
		logic       unit_en;
		logic       x_cap;
		logic       out_load;
	} f2c_cmd_t;

	typedef struct packed {
		logic search_done;
	} f2c_status_t;

endpackage

`default_nettype wire

[hw/rtl/frenet_to_cartesian.sv]
// Load item: accepted while the sequencer is idle, no result.
// Convert item: the result follows the scan of up to n waypoints, n the waypoints in use,
// over the single read port, the 32-step root, the 62-step divide and any rsp_stall on the
// previous result. Items are taken in the cycle after the result is loaded, so a new convert
// is not taken before the last one is through. Reset clears the sequencer and the output
// valid and sets waypoint_count to 2; the waypoint memories hold unknown data until loaded.
// ----------------------------------------------------------------------------
// frenet_to_cartesian
// Converts Frenet positions to Cartesian ones over a closed waypoint map.
// ----------------------------------------------------------------------------
`default_nettype none

module frenet_to_cartesian #(
	parameter int MAX_WAYPOINTS = f2c_pkg::MAX_WP_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire logic                          action,
	input  wire logic [7:0]                    wp_index,
	input  wire logic [30:0]                   wp_arc,
	input  wire logic signed [31:0]            wp_east,
	input  wire logic signed [31:0]            wp_north,
	input  wire logic [30:0]                   query_arc,
	input  wire logic signed [31:0]            query_offset,
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output logic signed [31:0]                 pos_east,
	output logic signed [31:0]                 pos_north,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [f2c_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	import f2c_pkg::*;

	f2c_cmd_t           cmd;
	f2c_status_t        status;
	logic               wr_en;
	logic [COUNT_W-1:0] waypoint_count_q;
	logic               reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_WAYPOINT_COUNT);
	assign prdata  = reg_sel ? 32'(waypoint_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waypoint_count_q <= COUNT_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			waypoint_count_q <= pwdata[COUNT_W-1:0];
		end
	end

	f2c_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.action    (action),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.cmd       (cmd),
		.wr_en     (wr_en)
	);

	f2c_datapath #(
		.MAX_WAYPOINTS (MAX_WAYPOINTS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.wr_en          (wr_en),
		.wp_index       (wp_index),
		.wp_arc         (wp_arc),
		.wp_east        (wp_east),
		.wp_north       (wp_north),
		.query_arc      (query_arc),
		.query_offset   (query_offset),
		.waypoint_count (waypoint_count_q),
		.pos_east       (pos_east),
		.pos_north      (pos_north)
	);

endmodule

`default_nettype wire

[hw/rtl/f2c_ctrl.sv]
// ----------------------------------------------------------------------------
// f2c_ctrl
// Sequencer of the converter: handshakes and the command for every step.
// ----------------------------------------------------------------------------
`default_nettype none

module f2c_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	input  wire logic               action,
	output logic                    req_stall,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	input  wire f2c_pkg::f2c_status_t status,
	output f2c_pkg::f2c_cmd_t       cmd,
	output logic                    wr_en
);
	import f2c_pkg::*;

	localparam logic [4:0] ST_IDLE     = 5'd0;
	localparam logic [4:0] ST_SEARCH   = 5'd1;
	localparam logic [4:0] ST_RD_PREV  = 5'd2;
	localparam logic [4:0] ST_RD_NEXT  = 5'd3;
	localparam logic [4:0] ST_CAP_NEXT = 5'd4;
	localparam logic [4:0] ST_ABS      = 5'd5;
	localparam logic [4:0] ST_SQ0      = 5'd6;
	localparam logic [4:0] ST_SQ1      = 5'd7;
	localparam logic [4:0] ST_SQ2      = 5'd8;
	localparam logic [4:0] ST_SQRT_LD  = 5'd9;
	localparam logic [4:0] ST_SQRT     = 5'd10;
	localparam logic [4:0] ST_DIV_LD   = 5'd11;
	localparam logic [4:0] ST_DIV      = 5'd12;
	localparam logic [4:0] ST_UNIT     = 5'd13;
	localparam logic [4:0] ST_X0       = 5'd14;
	localparam logic [4:0] ST_X1       = 5'd15;
	localparam logic [4:0] ST_X2       = 5'd16;
	localparam logic [4:0] ST_X3       = 5'd17;
	localparam logic [4:0] ST_Y1       = 5'd18;
	localparam logic [4:0] ST_Y2       = 5'd19;
	localparam logic [4:0] ST_OUT      = 5'd20;

	logic [4:0]        state_q, state_d;
	logic [ITER_W-1:0] iter_q, iter_d;
	logic              rsp_valid_q;
	logic              accept;
	logic              slot_free;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign wr_en     = accept && (action == ACT_LOAD);
	assign rsp_valid = rsp_valid_q;
	assign slot_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_d = state_q;
		iter_d  = iter_q;
		cmd     = '0;
		cmd.mul_sel = MUL_AXAX;
		cmd.acc_op  = ACC_HOLD;
		cmd.search_start = accept && (action == ACT_CONVERT);
		case (state_q)
			ST_IDLE: begin
				if (accept && (action == ACT_CONVERT)) state_d = ST_SEARCH;
			end
			ST_SEARCH: begin
				cmd.search_step = 1'b1;
				if (status.search_done) state_d = ST_RD_PREV;
			end
			ST_RD_PREV: begin
				cmd.rd_prev = 1'b1;
				state_d = ST_RD_NEXT;
			end
			ST_RD_NEXT: begin
				cmd.rd_next = 1'b1;
				state_d = ST_CAP_NEXT;
			end
			ST_CAP_NEXT: begin
				cmd.cap_next = 1'b1;
				state_d = ST_ABS;
			end
			ST_ABS: begin
				cmd.abs_en = 1'b1;
				state_d = ST_SQ0;
			end
			ST_SQ0: begin
				cmd.mul_sel = MUL_AXAX;
				cmd.acc_op  = ACC_CLR;
				state_d = ST_SQ1;
			end
			ST_SQ1: begin
				cmd.mul_sel = MUL_AYAY;
				cmd.acc_op  = ACC_ADD;
				state_d = ST_SQ2;
			end
			ST_SQ2: begin
				cmd.acc_op = ACC_ADD;
				state_d = ST_SQRT_LD;
			end
			ST_SQRT_LD: begin
				cmd.sqrt_start = 1'b1;
				iter_d  = SQRT_STEPS - 1'b1;
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				iter_d = iter_q - 1'b1;
				if (iter_q == '0) state_d = ST_DIV_LD;
			end
			ST_DIV_LD: begin
				cmd.div_start = 1'b1;
				iter_d  = DIV_STEPS - 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				iter_d = iter_q - 1'b1;
				if (iter_q == '0) state_d = ST_UNIT;
			end
			ST_UNIT: begin
				cmd.unit_en = 1'b1;
				state_d = ST_X0;
			end
			ST_X0: begin
				cmd.mul_sel = MUL_SEG_C;
				cmd.acc_op  = ACC_LOAD_X0;
				state_d = ST_X1;
			end
			ST_X1: begin
				cmd.mul_sel = MUL_D_SN;
				cmd.acc_op  = ACC_ADD;
				state_d = ST_X2;
			end
			ST_X2: begin
				cmd.acc_op = ACC_ADD;
				state_d = ST_X3;
			end
			ST_X3: begin
				cmd.x_cap   = 1'b1;
				cmd.mul_sel = MUL_SEG_SN;
				cmd.acc_op  = ACC_LOAD_Y0;
				state_d = ST_Y1;
			end
			ST_Y1: begin
				cmd.mul_sel = MUL_D_C;
				cmd.acc_op  = ACC_ADD;
				state_d = ST_Y2;
			end
			ST_Y2: begin
				cmd.acc_op = ACC_SUB;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			iter_q  <= iter_d;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/f2c_datapath.sv]
// ----------------------------------------------------------------------------
// f2c_datapath
// Waypoint memories, segment scan, square root, dividers and the
// multiply-accumulate path that forms the Cartesian position.
// ----------------------------------------------------------------------------
`default_nettype none

module f2c_datapath #(
	parameter int MAX_WAYPOINTS = f2c_pkg::MAX_WP_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire f2c_pkg::f2c_cmd_t             cmd,
	output f2c_pkg::f2c_status_t               status,
	input  wire logic                          wr_en,
	input  wire logic [7:0]                    wp_index,
	input  wire logic [30:0]                   wp_arc,
	input  wire logic signed [31:0]            wp_east,
	input  wire logic signed [31:0]            wp_north,
	input  wire logic [30:0]                   query_arc,
	input  wire logic signed [31:0]            query_offset,
	input  wire logic [f2c_pkg::COUNT_W-1:0]   waypoint_count,
	output logic signed [31:0]                 pos_east,
	output logic signed [31:0]                 pos_north
);
	import f2c_pkg::*;

	localparam int DEPTH = (MAX_WAYPOINTS < STORE_DEPTH) ? MAX_WAYPOINTS : STORE_DEPTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = AW + 1;
	localparam logic signed [31:0] UNIT_ONE = 32'sd1 <<< UNIT_BITS;

	function automatic logic signed [31:0] round_sat(input logic signed [65:0] v);
		logic signed [65:0] t;
		logic signed [35:0] r;
		t = v + (66'sd1 <<< (UNIT_BITS - 1));
		r = 36'(t >>> UNIT_BITS);
		if (r > 36'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
		else if (r < -36'sh0_8000_0000) return 32'sh8000_0000;
		else return r[31:0];
	endfunction

	logic [30:0]        arc_mem   [DEPTH];
	logic signed [31:0] east_mem  [DEPTH];
	logic signed [31:0] north_mem [DEPTH];
	logic [30:0]        rd_arc_q;
	logic signed [31:0] rd_east_q, rd_north_q;
	logic [AW-1:0]      rd_addr;
	logic               wr_ok;

	logic [COUNT_W-1:0] n_clamp;
	logic [CW-1:0]      n_eff;
	logic [CW-1:0]      scan_q, chk_idx_q, cnt, pv, nx;
	logic               chk_v_q, below, hit;
	logic [AW-1:0]      prev_q, nxt_q;

	logic [30:0]        s_q, arc0_q;
	logic signed [31:0] d_q, x0_q, y0_q, seg_q;
	logic signed [32:0] dx_q, dy_q;
	logic [32:0]        magx, magy, mx1, my1, mx2, my2;
	logic               sh1, sh2;
	logic [30:0]        ax_q, ay_q;
	logic               negx_q, negy_q;

	logic signed [31:0] ma, mb;
	logic signed [63:0] mul_p_s1;
	logic signed [65:0] acc_q;

	logic [63:0]        sq_v_q;
	logic [34:0]        sq_rem_q, sq_rn, sq_trial;
	logic [31:0]        sq_root_q;

	logic [31:0]        len_q;
	logic [61:0]        numx_q, numy_q;
	logic [31:0]        remx_q, remy_q, qx_q, qy_q, capx, capy;
	logic [32:0]        rnx, rny;
	logic               gex, gey;
	logic signed [31:0] c_q, sn_q, x_q;

	assign wr_ok = wr_en && ({1'b0, wp_index} < 9'(DEPTH));

	always_comb begin
		if (cmd.rd_next) rd_addr = nxt_q;
		else if (cmd.rd_prev) rd_addr = prev_q;
		else rd_addr = scan_q[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			arc_mem[wp_index[AW-1:0]]   <= wp_arc;
			east_mem[wp_index[AW-1:0]]  <= wp_east;
			north_mem[wp_index[AW-1:0]] <= wp_north;
		end
		rd_arc_q   <= arc_mem[rd_addr];
		rd_east_q  <= east_mem[rd_addr];
		rd_north_q <= north_mem[rd_addr];
	end

	always_comb begin
		if (waypoint_count < COUNT_W'(2)) n_clamp = COUNT_W'(2);
		else if (waypoint_count > COUNT_W'(DEPTH)) n_clamp = COUNT_W'(DEPTH);
		else n_clamp = waypoint_count;
		n_eff = n_clamp[CW-1:0];
		below = (s_q <= rd_arc_q);
		hit   = chk_v_q && (below || ((chk_idx_q + CW'(1)) == n_eff));
		cnt   = below ? chk_idx_q : n_eff;
		pv    = (cnt == '0) ? '0 : cnt - CW'(1);
		nx    = ((pv + CW'(1)) == n_eff) ? '0 : pv + CW'(1);
	end

	assign status.search_done = hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q    <= '0;
			chk_idx_q <= '0;
			chk_v_q   <= 1'b0;
		end else if (cmd.search_start) begin
			scan_q  <= '0;
			chk_v_q <= 1'b0;
		end else if (cmd.search_step) begin
			scan_q    <= scan_q + CW'(1);
			chk_idx_q <= scan_q;
			chk_v_q   <= 1'b1;
		end
	end

	always_comb begin
		magx = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
		magy = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);
		sh1  = (magx[32:31] != 2'b00) || (magy[32:31] != 2'b00);
		mx1  = sh1 ? (magx >> 1) : magx;
		my1  = sh1 ? (magy >> 1) : magy;
		sh2  = mx1[31] || my1[31];
		mx2  = sh2 ? (mx1 >> 1) : mx1;
		my2  = sh2 ? (my1 >> 1) : my1;
	end

	always_comb begin
		case (cmd.mul_sel)
			MUL_AXAX: begin
				ma = $signed({1'b0, ax_q});
				mb = $signed({1'b0, ax_q});
			end
			MUL_AYAY: begin
				ma = $signed({1'b0, ay_q});
				mb = $signed({1'b0, ay_q});
			end
			MUL_SEG_C: begin
				ma = seg_q;
				mb = c_q;
			end
			MUL_D_SN: begin
				ma = d_q;
				mb = sn_q;
			end
			MUL_SEG_SN: begin
				ma = seg_q;
				mb = sn_q;
			end
			MUL_D_C: begin
				ma = d_q;
				mb = c_q;
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_comb begin
		sq_rn    = {sq_rem_q[32:0], sq_v_q[63:62]};
		sq_trial = {1'b0, sq_root_q, 2'b01};
		rnx      = {remx_q, numx_q[61]};
		rny      = {remy_q, numy_q[61]};
		gex      = (rnx >= {1'b0, len_q});
		gey      = (rny >= {1'b0, len_q});
		capx     = (qx_q > 32'(UNIT_ONE)) ? 32'(UNIT_ONE) : qx_q;
		capy     = (qy_q > 32'(UNIT_ONE)) ? 32'(UNIT_ONE) : qy_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.search_start) begin
			s_q <= query_arc;
			d_q <= query_offset;
		end
		if (cmd.search_step && hit) begin
			prev_q <= pv[AW-1:0];
			nxt_q  <= nx[AW-1:0];
		end
		if (cmd.rd_next) begin
			arc0_q <= rd_arc_q;
			x0_q   <= rd_east_q;
			y0_q   <= rd_north_q;
		end
		if (cmd.cap_next) begin
			dx_q  <= 33'(rd_east_q) - 33'(x0_q);
			dy_q  <= 33'(rd_north_q) - 33'(y0_q);
			seg_q <= $signed({1'b0, s_q}) - $signed({1'b0, arc0_q});
		end
		if (cmd.abs_en) begin
			ax_q   <= mx2[30:0];
			ay_q   <= my2[30:0];
			negx_q <= dx_q[32];
			negy_q <= dy_q[32];
		end

		mul_p_s1 <= ma * mb;
		case (cmd.acc_op)
			ACC_CLR:     acc_q <= '0;
			ACC_LOAD_X0: acc_q <= {{4{x0_q[31]}}, x0_q, 30'd0};
			ACC_LOAD_Y0: acc_q <= {{4{y0_q[31]}}, y0_q, 30'd0};
			ACC_ADD:     acc_q <= acc_q + 66'(mul_p_s1);
			ACC_SUB:     acc_q <= acc_q - 66'(mul_p_s1);
			default:     acc_q <= acc_q;
		endcase

		if (cmd.sqrt_start) begin
			sq_v_q    <= {1'b0, acc_q[62:0]};
			sq_rem_q  <= '0;
			sq_root_q <= '0;
		end else if (cmd.sqrt_step) begin
			sq_v_q <= {sq_v_q[61:0], 2'b00};
			if (sq_rn >= sq_trial) begin
				sq_rem_q  <= sq_rn - sq_trial;
				sq_root_q <= {sq_root_q[30:0], 1'b1};
			end else begin
				sq_rem_q  <= sq_rn;
				sq_root_q <= {sq_root_q[30:0], 1'b0};
			end
		end

		if (cmd.div_start) begin
			len_q  <= sq_root_q;
			numx_q <= {1'b0, ax_q, 30'd0} + 62'(sq_root_q >> 1);
			numy_q <= {1'b0, ay_q, 30'd0} + 62'(sq_root_q >> 1);
			remx_q <= '0;
			remy_q <= '0;
			qx_q   <= '0;
			qy_q   <= '0;
		end else if (cmd.div_step) begin
			numx_q <= {numx_q[60:0], 1'b0};
			numy_q <= {numy_q[60:0], 1'b0};
			remx_q <= gex ? 32'(rnx - {1'b0, len_q}) : rnx[31:0];
			remy_q <= gey ? 32'(rny - {1'b0, len_q}) : rny[31:0];
			qx_q   <= {qx_q[30:0], gex};
			qy_q   <= {qy_q[30:0], gey};
		end

		if (cmd.unit_en) begin
			if (len_q == '0) begin
				c_q  <= UNIT_ONE;
				sn_q <= '0;
			end else begin
				c_q  <= negx_q ? -$signed(capx) : $signed(capx);
				sn_q <= negy_q ? -$signed(capy) : $signed(capy);
			end
		end

		if (cmd.x_cap) x_q <= round_sat(acc_q);
		if (cmd.out_load) begin
			pos_east  <= x_q;
			pos_north <= round_sat(acc_q);
		end
	end

endmodule

`default_nettype wire

[hw/rtl/f2c_checker.sv]
// ----------------------------------------------------------------------------
// f2c_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "frenet_to_cartesian_assert.svh"

module f2c_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        req_valid,
	input wire logic                        req_stall,
	input wire logic                        action,
	input wire logic                        rsp_valid,
	input wire logic                        rsp_stall,
	input wire logic signed [31:0]          pos_east,
	input wire logic signed [31:0]          pos_north
);
	import f2c_pkg::*;

	`F2C_ASSERT_NEXT(a_convert_busy, req_valid && !req_stall && action == ACT_CONVERT, req_stall)
	`F2C_ASSERT_NEXT(a_load_silent, req_valid && !req_stall && action == ACT_LOAD && !rsp_valid, !rsp_valid)
	`F2C_ASSERT_IMP(a_result_from_work, $rose(rsp_valid), $past(req_stall))
	`F2C_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
	`F2C_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(pos_east) && $stable(pos_north))

endmodule

bind frenet_to_cartesian f2c_checker u_f2c_checker (.*);

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Frenet to Cartesian converter: waypoint maps are
// loaded, the count register is swept across its range, and every conversion is checked
// against an in-bench fixed-point predictor or a directed expected value under random idling.
// ----------------------------------------------------------------------------

module tb;
	import f2c_pkg::*;

	typedef struct {
		logic signed [31:0] east;
		logic signed [31:0] north;
	} position_t;

	typedef struct {
		logic               act;
		logic [7:0]         idx;
		logic [30:0]        arc;
		logic signed [31:0] east;
		logic signed [31:0] north;
		logic [30:0]        qarc;
		logic signed [31:0] qoff;
		bit                 typed;
		logic signed [31:0] exp_east;
		logic signed [31:0] exp_north;
	} stim_row_t;

	logic clk, arst_n;
	logic req_valid, req_stall, action;
	logic [7:0] wp_index;
	logic [30:0] wp_arc, query_arc;
	logic signed [31:0] wp_east, wp_north, query_offset;
	logic rsp_valid, rsp_stall;
	logic signed [31:0] pos_east, pos_north;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	logic [30:0]        map_arc[STORE_DEPTH];
	logic signed [31:0] map_east[STORE_DEPTH];
	logic signed [31:0] map_north[STORE_DEPTH];
	bit                 map_loaded[STORE_DEPTH];
	logic [COUNT_W-1:0] wp_count_reg;
	position_t          pending_pos[$];
	int                 fail_count;
	int                 burst_left;
	longint             cycle_count;

	localparam longint CYCLE_LIMIT = 1500000;
	localparam int     SETTLE_CYCLES = 400;

	frenet_to_cartesian DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.action(action), .wp_index(wp_index), .wp_arc(wp_arc),
		.wp_east(wp_east), .wp_north(wp_north),
		.query_arc(query_arc), .query_offset(query_offset),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.pos_east(pos_east), .pos_north(pos_north),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint unit_component(longint unsigned mag, longint unsigned len,
			bit neg);
		longint unsigned q;
		q = ((mag << UNIT_BITS) + (len >> 1)) / len;
		if (q > (64'd1 << UNIT_BITS)) q = 64'd1 << UNIT_BITS;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic signed [31:0] round_saturate(longint v);
		longint r;
		r = (v + (longint'(1) << (UNIT_BITS - 1))) >>> UNIT_BITS;
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		if (r < -64'sd2147483648) r = -64'sd2147483648;
		return r[31:0];
	endfunction

	function automatic int active_waypoints();
		int n;
		n = wp_count_reg;
		if (n < 2) n = 2;
		if (n > STORE_DEPTH) n = STORE_DEPTH;
		return n;
	endfunction

	function automatic position_t convert_position(logic [30:0] qarc,
			logic signed [31:0] qoff);
		int n, prev, nxt;
		longint s, d, seg, dx, dy, x0, y0, c, sn;
		longint unsigned ax, ay, len;
		position_t p;
		n = active_waypoints();
		s = longint'({33'd0, qarc});
		d = longint'(qoff);
		prev = 0;
		while (prev < n && s > longint'({33'd0, map_arc[prev]})) prev++;
		prev = (prev == 0) ? 0 : prev - 1;
		nxt = (prev + 1) % n;
		x0 = longint'(map_east[prev]);
		y0 = longint'(map_north[prev]);
		dx = longint'(map_east[nxt]) - x0;
		dy = longint'(map_north[nxt]) - y0;
		seg = s - longint'({33'd0, map_arc[prev]});
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		while (ax >= (64'd1 << 31) || ay >= (64'd1 << 31)) begin
			ax >>= 1;
			ay >>= 1;
		end
		len = int_sqrt(ax * ax + ay * ay);
		if (len == 0) begin
			c = longint'(1) << UNIT_BITS;
			sn = 0;
		end else begin
			c = unit_component(ax, len, dx < 0);
			sn = unit_component(ay, len, dy < 0);
		end
		p.east = round_saturate((x0 <<< UNIT_BITS) + seg * c + d * sn);
		p.north = round_saturate((y0 <<< UNIT_BITS) + seg * sn - d * c);
		return p;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer, or later after a random idle gap.
	task automatic send_item(stim_row_t r);
		position_t p;
		int gap;
		req_valid = 1'b1;
		action = r.act;
		wp_index = r.idx;
		wp_arc = r.arc;
		wp_east = r.east;
		wp_north = r.north;
		query_arc = r.qarc;
		query_offset = r.qoff;
		do @(posedge clk); while (req_stall);
		if (r.act == ACT_LOAD) begin
			map_arc[r.idx] = r.arc;
			map_east[r.idx] = r.east;
			map_north[r.idx] = r.north;
			map_loaded[r.idx] = 1'b1;
		end else begin
			if (r.typed) begin
				p.east = r.exp_east;
				p.north = r.exp_north;
			end else begin
				p = convert_position(r.qarc, r.qoff);
			end
			pending_pos = {pending_pos, p};
		end
		@(negedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	task automatic drain_and_settle();
		req_valid = 1'b0;
		wait (pending_pos.size() == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_count(logic [COUNT_W-1:0] value);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = PADDR_W'(4 * REG_WAYPOINT_COUNT);
		pwdata = 32'(value);
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		wp_count_reg = value;
	endtask

	function automatic stim_row_t load_row(int idx, logic [30:0] arc, logic signed [31:0] e,
			logic signed [31:0] no);
		stim_row_t r;
		r = '{default: '0};
		r.act = ACT_LOAD;
		r.idx = idx[7:0];
		r.arc = arc;
		r.east = e;
		r.north = no;
		return r;
	endfunction

	function automatic stim_row_t convert_row(logic [30:0] qa, logic signed [31:0] qo);
		stim_row_t r;
		r = '{default: '0};
		r.act = ACT_CONVERT;
		r.idx = 8'($urandom);
		r.arc = 31'($urandom);
		r.east = $urandom;
		r.north = $urandom;
		r.qarc = qa;
		r.qoff = qo;
		return r;
	endfunction

	function automatic logic signed [31:0] random_offset();
		if ($urandom_range(0, 5) == 0) return $urandom;
		return $signed($urandom_range(0, 32'h1FFFF)) - 32'sh10000;
	endfunction

	task automatic run_phase(logic [COUNT_W-1:0] count, int items);
		int n, step_max;
		bit rebuild, noisy;
		logic [30:0] arc_pos;
		logic signed [31:0] ce, cn;
		longint hi;
		drain_and_settle();
		write_count(count);
		n = active_waypoints();
		rebuild = (n <= 48);
		noisy = ($urandom_range(0, 9) == 0);
		step_max = (n > 64) ? 32'h3FFFFF : 32'hFFFFFF;
		arc_pos = 31'($urandom_range(0, 4096));
		ce = $signed($urandom_range(0, 32'h7FFFFF)) - 32'sh400000;
		cn = $signed($urandom_range(0, 32'h7FFFFF)) - 32'sh400000;
		for (int i = 0; i < n; i++) begin
			if (rebuild || !map_loaded[i]) begin
				if (noisy)
					send_item(load_row(i, 31'($urandom), $urandom, $urandom));
				else
					send_item(load_row(i, arc_pos, ce, cn));
			end
			arc_pos += 31'($urandom_range(0, step_max));
			ce += $signed($urandom_range(0, 32'h1FFFF)) - 32'sh10000;
			cn += $signed($urandom_range(0, 32'h1FFFF)) - 32'sh10000;
		end
		for (int k = 0; k < items; k++) begin
			if ($urandom_range(0, 9) < 2) begin
				send_item(load_row($urandom_range(0, 255), 31'($urandom), $urandom,
					$urandom));
			end else begin
				hi = longint'({33'd0, map_arc[n-1]}) + 8192;
				if (hi > 64'h7FFFFFFF) hi = 64'h7FFFFFFF;
				if ($urandom_range(0, 6) == 0)
					send_item(convert_row(31'($urandom), random_offset()));
				else
					send_item(convert_row(31'($urandom_range(0, 32'(hi))),
						random_offset()));
			end
		end
	endtask

	stim_row_t directed[$];

	task automatic queue_row(stim_row_t r);
		directed = {directed, r};
	endtask

	initial begin
		stim_row_t r;
		arst_n = 1'b0;
		req_valid = 1'b0;
		action = ACT_LOAD;
		wp_index = '0;
		wp_arc = '0;
		wp_east = '0;
		wp_north = '0;
		query_arc = '0;
		query_offset = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		fail_count = 0;
		burst_left = 4;
		wp_count_reg = COUNT_RESET;
		foreach (map_loaded[i]) map_loaded[i] = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		queue_row(load_row(0, 31'd0, 32'sd0, 32'sd0));
		queue_row(load_row(1, 31'd2560, 32'sd2560, 32'sd0));
		r = convert_row(31'd1280, 32'sd0);
		r.typed = 1; r.exp_east = 32'sd1280; r.exp_north = 32'sd0;
		queue_row(r);
		r = convert_row(31'd0, 32'sd256);
		r.typed = 1; r.exp_east = 32'sd0; r.exp_north = -32'sd256;
		queue_row(r);
		queue_row(convert_row(31'h7FFFFFFF, 32'sh7FFFFFFF));
		queue_row(convert_row(31'h7FFFFFFF, 32'sh80000000));
		queue_row(convert_row(31'd2560, -32'sd1));
		queue_row(load_row(255, 31'h7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF));
		queue_row(load_row(1, 31'd512, 32'sd0, 32'sd0));
		r = convert_row(31'd256, 32'sd256);
		r.typed = 1; r.exp_east = 32'sd256; r.exp_north = -32'sd256;
		queue_row(r);
		queue_row(load_row(0, 31'd0, 32'sd0, 32'sh80000000));
		queue_row(load_row(1, 31'd256, 32'sd256, 32'sh80000000));
		r = convert_row(31'd0, 32'sh7FFFFFFF);
		r.typed = 1; r.exp_east = 32'sd0; r.exp_north = 32'sh80000000;
		queue_row(r);
		queue_row(load_row(0, 31'h7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF));
		queue_row(load_row(1, 31'd0, 32'sh7FFFFFFF, 32'sh80000000));
		queue_row(convert_row(31'd100, 32'sh7FFFFFFF));
		queue_row(convert_row(31'h7FFFFFFF, 32'sh80000000));
		queue_row(convert_row(31'h40000000, 32'sd12345));
		foreach (directed[i]) send_item(directed[i]);

		run_phase(9'd1, 30);
		run_phase(9'd256, 50);
		run_phase(9'd511, 40);
		run_phase(9'd0, 30);
		run_phase(9'd2, 40);
		for (int ph = 0; ph < 9; ph++)
			run_phase(9'($urandom_range(3, 40)), 15);
		run_phase(9'($urandom_range(257, 511)), 20);

		drain_and_settle();
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		int mode, left;
		rsp_stall = 1'b0;
		mode = 0;
		left = 0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(20, 300);
			end
			left--;
			case (mode)
				0: rsp_stall = 1'b0;
				1: rsp_stall = ($urandom_range(0, 2) == 0);
				2: rsp_stall = ($urandom_range(0, 15) != 0);
				default: rsp_stall = ~rsp_stall;
			endcase
		end
	end

	always @(posedge clk) begin
		position_t p;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_pos.size() == 0) begin
				$display("%0t: unexpected transfer east %0d north %0d",
					$time, pos_east, pos_north);
				fail_count++;
			end else begin
				p = pending_pos.pop_front();
				if (pos_east !== p.east) begin
					$display("%0t: pos_east expected %0d actual %0d", $time, p.east, pos_east);
					fail_count++;
				end
				if (pos_north !== p.north) begin
					$display("%0t: pos_north expected %0d actual %0d",
						$time, p.north, pos_north);
					fail_count++;
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("%0t: timeout with %0d results outstanding",
					$time, pending_pos.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

endmodule
